// ----- rtl/crmc_pkg.sv -----
// Shared types, constants and helper functions for the challenge-response mix cipher.
// No dependencies; used by challenge_response_mix_cipher and the testbench.
package crmc_pkg;

    localparam int ScrWidth = 16;
    localparam int ScrDepth = 64;
    localparam int AddrBits = $clog2(ScrDepth);

    localparam logic [6:0]  StepClearLast = 7'(ScrDepth - 1);
    localparam logic [6:0]  StepSeedLast  = 7'd9;
    localparam logic [6:0]  StepRoundLast = 7'd65;
    localparam logic [2:0]  RoundLast     = 3'd7;
    localparam logic [10:0] PtrOneInit    = 11'h409;
    localparam logic [10:0] PtrTwoInit    = 11'h40e;
    localparam logic [10:0] PtrThreeInit  = 11'h410;
    localparam logic [10:0] KeyHiAddr     = 11'h40a;
    localparam logic [10:0] KeyLoAddr     = 11'h40b;
    localparam logic [39:0] AccBInit      = 40'h30000;
    localparam logic [39:0] ShiftBias     = 40'h80000;
    localparam logic [39:0] ShiftSpan     = 40'h280000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_SEED,
        ST_ROUND,
        ST_KEY_A,
        ST_KEY_B,
        ST_KEY_C
    } t_state;

    function automatic logic [AddrBits-1:0] slot(input logic [10:0] a);
        slot = {a[10], a[4:0]};
    endfunction

    function automatic logic [15:0] mid(input logic [39:0] a);
        mid = a[31:16];
    endfunction

    function automatic logic [39:0] set_mid(input logic [39:0] a, input logic [15:0] v);
        set_mid = {a[39:32], v, a[15:0]};
    endfunction

    function automatic logic [39:0] set_low(input logic [39:0] a, input logic [15:0] v);
        set_low = {a[39:16], v};
    endfunction

    // count in h[5:0]; h[6] selects right shift by 64 - count
    function automatic logic [39:0] vshift(input logic [39:0] v, input logic [15:0] h);
        logic [5:0] s;
        logic [6:0] r;
        s = h[5:0];
        r = 7'd64 - {1'b0, s};
        if (s == 6'd0) begin
            vshift = v;
        end else if (h[6]) begin
            vshift = v >> r;
        end else begin
            vshift = v << s;
        end
    endfunction

    function automatic logic [10:0] seed_addr(input logic [3:0] i);
        unique case (i)
            4'd0:    seed_addr = 11'h403;
            4'd1:    seed_addr = 11'h408;
            4'd2:    seed_addr = 11'h409;
            4'd3:    seed_addr = 11'h40a;
            4'd4:    seed_addr = 11'h40b;
            4'd5:    seed_addr = 11'h40c;
            4'd6:    seed_addr = 11'h40d;
            4'd7:    seed_addr = 11'h40e;
            4'd8:    seed_addr = 11'h40f;
            default: seed_addr = 11'h410;
        endcase
    endfunction

    function automatic logic [15:0] seed_data(input logic [3:0] i, input logic [10:0] sum);
        unique case (i)
            4'd0:    seed_data = 16'h0008;
            4'd1:    seed_data = 16'h170a;
            4'd2:    seed_data = 16'h7489 + {5'b0, sum};
            4'd3:    seed_data = 16'h05ef;
            4'd4:    seed_data = 16'he0aa;
            4'd5:    seed_data = 16'hdaf4;
            4'd6:    seed_data = 16'hb157;
            4'd7:    seed_data = 16'h6bbe;
            4'd8:    seed_data = 16'hc3b6;
            default: seed_data = {5'b0, sum} + 16'd8;
        endcase
    endfunction

endpackage

// ----- rtl/crmc_ram.sv -----
// Generic single-port RAM with registered read data.
// Depends on nothing; sized by its parameters.
module crmc_ram #(
    parameter int Width = 16,
    parameter int Depth = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_addr,
    input  logic [Width-1:0]         i_wdata,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/challenge_response_mix_cipher.sv -----
// Top level of the challenge-response mix cipher: sequencer, 40-bit datapath, scratch RAM.
// Depends on crmc_pkg and crmc_ram.
//
// channel | direction | handshake          | payload
// request | in        | i_valid / o_stall  | i_challenge_high, i_challenge_low
// key     | out       | o_valid / i_stall  | o_key
//
// A request passes through idle, where it is taken, then clears the scratch RAM, seeds it,
// runs 7 rounds and reads the key into the output register.
// Every scratch access goes through the single RAM port, one step at a time.
// Reset is synchronous, active low, and returns the sequencer to idle.
// A new request is taken while the previous key still waits in the output register;
// a finished key that finds the output register still held waits in readout.
module challenge_response_mix_cipher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_challenge_high,
    input  logic [31:0] i_challenge_low,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_key
);
    crmc_pkg::t_state r_state, n_state;

    logic [6:0]  r_step, n_step;
    logic [2:0]  r_round, n_round;
    logic [63:0] r_bytes, n_bytes;
    logic [10:0] r_sum, n_sum;
    logic [39:0] r_a0, n_a0, r_a1, n_a1;
    logic [10:0] r_p1, n_p1, r_p2, n_p2, r_p3, n_p3;
    logic [15:0] r_h0, n_h0, r_h1, n_h1, r_l0, n_l0, r_key_hi, n_key_hi;
    logic [3:0]  r_l1, n_l1, r_nlo, n_nlo, r_carry, n_carry;
    logic [31:0] r_key, n_key;
    logic        r_ovalid, n_ovalid;

    logic                          ram_we;
    logic [crmc_pkg::AddrBits-1:0] ram_addr;
    logic [15:0]                   ram_wdata, ram_q;
    logic                          key_leave;

    crmc_ram #(
        .Width (crmc_pkg::ScrWidth),
        .Depth (crmc_pkg::ScrDepth)
    ) u_scratch (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_q)
    );

    assign key_leave = !r_ovalid || !i_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            crmc_pkg::ST_IDLE:  if (i_valid) n_state = crmc_pkg::ST_CLEAR;
            crmc_pkg::ST_CLEAR: if (r_step == crmc_pkg::StepClearLast) n_state = crmc_pkg::ST_SEED;
            crmc_pkg::ST_SEED:  if (r_step == crmc_pkg::StepSeedLast) n_state = crmc_pkg::ST_ROUND;
            crmc_pkg::ST_ROUND: begin
                if (r_step == crmc_pkg::StepRoundLast && r_round == crmc_pkg::RoundLast) begin
                    n_state = crmc_pkg::ST_KEY_A;
                end
            end
            crmc_pkg::ST_KEY_A: n_state = crmc_pkg::ST_KEY_B;
            crmc_pkg::ST_KEY_B: n_state = crmc_pkg::ST_KEY_C;
            crmc_pkg::ST_KEY_C: if (key_leave) n_state = crmc_pkg::ST_IDLE;
            default:            n_state = crmc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        logic [39:0] t0;
        logic [39:0] t1;
        logic [10:0] sum;
        n_step   = r_step + 7'd1;
        n_round  = r_round;
        n_bytes  = r_bytes;
        n_sum    = r_sum;
        n_a0     = r_a0;
        n_a1     = r_a1;
        n_p1     = r_p1;
        n_p2     = r_p2;
        n_p3     = r_p3;
        n_h0     = r_h0;
        n_h1     = r_h1;
        n_l0     = r_l0;
        n_l1     = r_l1;
        n_nlo    = r_nlo;
        n_carry  = r_carry;
        n_key_hi = r_key_hi;
        n_key    = r_key;
        n_ovalid = r_ovalid && i_stall;
        ram_we    = 1'b0;
        ram_wdata = '0;
        ram_addr  = crmc_pkg::slot(r_p2);
        t0 = '0;
        t1 = '0;
        sum = '0;
        unique case (r_state)
            crmc_pkg::ST_IDLE: begin
                n_step = '0;
                for (int i = 0; i < 4; i++) begin
                    sum = sum + {3'b0, i_challenge_high[8*i +: 8]}
                              + {3'b0, i_challenge_low[8*i +: 8]};
                end
                if (i_valid) begin
                    n_bytes = {i_challenge_high, i_challenge_low};
                    n_sum   = sum;
                end
            end
            crmc_pkg::ST_CLEAR: begin
                ram_we   = 1'b1;
                ram_addr = r_step[crmc_pkg::AddrBits-1:0];
                if (r_step == crmc_pkg::StepClearLast) n_step = '0;
            end
            crmc_pkg::ST_SEED: begin
                ram_we    = 1'b1;
                ram_addr  = crmc_pkg::slot(crmc_pkg::seed_addr(r_step[3:0]));
                ram_wdata = crmc_pkg::seed_data(r_step[3:0], r_sum);
                if (r_step == crmc_pkg::StepSeedLast) begin
                    n_step  = '0;
                    n_round = 3'd1;
                    n_p1    = crmc_pkg::PtrOneInit;
                    n_p2    = crmc_pkg::PtrTwoInit;
                    n_a0    = '0;
                    n_a1    = crmc_pkg::AccBInit | {36'b0, r_bytes[63:60]};
                    n_carry = r_bytes[59:56];
                    n_bytes = {r_bytes[55:0], 8'b0};
                end
            end
            crmc_pkg::ST_ROUND: begin
                case (r_step)
                    7'd0: begin
                        n_l1  = r_bytes[63:60];
                        n_nlo = r_bytes[59:56];
                        n_p3  = crmc_pkg::PtrThreeInit;
                        t0 = crmc_pkg::set_low(r_a0, {12'b0, r_bytes[59:56]});
                        t0 = {t0[19:0], 20'b0};
                        n_a0 = crmc_pkg::set_mid(t0, crmc_pkg::mid(t0) | {12'b0, r_carry});
                        ram_addr = crmc_pkg::slot(r_p2);
                    end
                    7'd1: begin n_h1 = ram_q; n_p2 = r_p2 + 11'd1; end
                    7'd2: begin n_a0 = {r_a0[23:0], 16'b0}; ram_addr = crmc_pkg::slot(r_p2); end
                    7'd3: begin n_h0 = ram_q; n_p2 = r_p2 + 11'd1; end
                    7'd4: begin
                        t0 = {{16{r_a0[39]}}, r_a0[39:16]};
                        t1 = {r_a1[15:0], 24'b0};
                        n_a1 = t1;
                        n_a0 = crmc_pkg::set_mid(t0, crmc_pkg::mid(t0) ^ crmc_pkg::mid(t1));
                        n_p2 = r_p2 - 11'd1;
                    end
                    7'd5: begin
                        t1 = crmc_pkg::set_mid(r_a1, {12'b0, r_l1});
                        t1 = {t1[27:0], 12'b0};
                        n_a1 = t1;
                        n_a0 = crmc_pkg::set_mid(r_a0, crmc_pkg::mid(r_a0) ^ crmc_pkg::mid(t1));
                        n_p2 = r_p2 - 11'd1;
                    end
                    7'd6: begin
                        n_p2 = r_p2 - 11'd1;
                        n_l0 = crmc_pkg::mid(r_a0);
                        ram_addr = crmc_pkg::slot(r_p1);
                    end
                    7'd7: begin n_a0 = crmc_pkg::set_low(r_a0, ram_q); n_p1 = r_p1 - 11'd1; end
                    7'd8: ram_addr = crmc_pkg::slot(r_p1);
                    7'd9: begin n_a0 = crmc_pkg::set_mid(r_a0, ram_q); n_p1 = r_p1 + 11'd1; end
                    7'd10: n_a0 = r_a0 + {24'b0, r_l0};
                    7'd11: begin
                        ram_we = 1'b1; ram_addr = crmc_pkg::slot(r_p1); ram_wdata = r_a0[15:0];
                        n_p1 = r_p1 - 11'd1;
                    end
                    7'd12: ram_addr = crmc_pkg::slot(r_p2);
                    7'd13: begin n_a1 = crmc_pkg::set_mid(r_a1, ram_q); n_p2 = r_p2 - 11'd1; end
                    7'd14: begin
                        ram_we = 1'b1; ram_addr = crmc_pkg::slot(r_p1);
                        ram_wdata = crmc_pkg::mid(r_a0);
                        n_a1 = crmc_pkg::set_mid(r_a1, crmc_pkg::mid(r_a1) ^ r_h0);
                        n_p1 = r_p1 + 11'd1;
                    end
                    7'd15: ram_addr = crmc_pkg::slot(r_p3);
                    7'd16: begin
                        n_l0 = ram_q; n_a1 = {16'b0, r_a1[39:16]}; n_p3 = r_p3 + 11'd1;
                    end
                    7'd17: ram_addr = crmc_pkg::slot(r_p2);
                    7'd18: begin n_a1 = crmc_pkg::set_mid(r_a1, ram_q); n_p2 = r_p2 - 11'd1; end
                    7'd19: begin
                        t1 = crmc_pkg::set_mid(r_a1, crmc_pkg::mid(r_a1) ^ r_h1);
                        n_a1 = t1 + r_a0;
                    end
                    7'd20: ram_addr = crmc_pkg::slot(r_p3);
                    7'd21: begin n_a0 = crmc_pkg::set_low(r_a0, ram_q); n_p3 = r_p3 + 11'd1; end
                    7'd22: begin n_a0 = r_a0 + 40'd1; n_p3 = r_p3 - 11'd1; end
                    7'd23: begin
                        ram_we = 1'b1; ram_addr = crmc_pkg::slot(r_p3); ram_wdata = r_a0[15:0];
                        n_p3 = r_p3 + 11'd1;
                    end
                    7'd24: begin
                        n_a0 = r_a0 + {24'b0, r_l0};
                        ram_addr = crmc_pkg::slot(r_p2);
                    end
                    7'd25: begin n_l0 = ram_q; n_p2 = r_p2 + 11'd1; end
                    7'd26: begin
                        t0 = 40'd0 - {35'b0, r_a0[4:0]};
                        t0 = {t0[23:0], 16'b0} - crmc_pkg::ShiftBias;
                        n_a0 = t0;
                        n_h0 = crmc_pkg::mid(t0);
                    end
                    7'd27: begin
                        t0 = r_a0 + crmc_pkg::ShiftSpan;
                        n_a0 = t0;
                        n_h1 = crmc_pkg::mid(t0);
                    end
                    7'd28: begin n_a0 = {r_a1[31:0], 8'b0}; n_p3 = crmc_pkg::PtrTwoInit; end
                    7'd29: begin n_a0 = crmc_pkg::vshift(r_a0, r_h0); n_p2 = r_p2 - 11'd1; end
                    7'd30: begin n_a1 = crmc_pkg::vshift(r_a1, r_h1); n_p2 = r_p2 - 11'd1; end
                    7'd31: begin n_a0 = r_a0 + r_a1; ram_addr = crmc_pkg::slot(r_p2); end
                    7'd32: begin n_h0 = ram_q; n_p2 = r_p2 + 11'd1; end
                    7'd33: begin
                        n_a0 = r_a0 + {{8{r_h0[15]}}, r_h0, r_l0};
                        ram_addr = crmc_pkg::slot(r_p3);
                    end
                    7'd34: begin n_a1 = crmc_pkg::set_low(r_a1, ram_q); n_p3 = r_p3 + 11'd1; end
                    7'd35: begin
                        ram_we = 1'b1; ram_addr = crmc_pkg::slot(r_p2); ram_wdata = r_a0[15:0];
                        n_p2 = r_p2 - 11'd1;
                    end
                    7'd36: begin
                        ram_we = 1'b1; ram_addr = crmc_pkg::slot(r_p2);
                        ram_wdata = crmc_pkg::mid(r_a0);
                    end
                    7'd37: ram_addr = crmc_pkg::slot(r_p1);
                    7'd38: begin
                        n_a0 = crmc_pkg::set_mid(r_a0, ram_q);
                        ram_addr = crmc_pkg::slot(r_p1);
                    end
                    7'd39: begin n_a1 = crmc_pkg::set_mid(r_a1, ~ram_q); n_p1 = r_p1 - 11'd1; end
                    7'd40: ram_addr = crmc_pkg::slot(r_p2);
                    7'd41: begin n_h0 = ram_q; n_p2 = r_p2 + 11'd1; end
                    7'd42: ram_addr = crmc_pkg::slot(r_p3);
                    7'd43: begin n_h1 = ram_q; n_p3 = r_p3 - 11'd2; end
                    7'd44: begin
                        n_a0 = crmc_pkg::set_mid(r_a0, crmc_pkg::mid(r_a0) & r_h1);
                        ram_addr = crmc_pkg::slot(r_p2);
                    end
                    7'd45: begin
                        n_h1 = ram_q; n_p2 = r_p2 + 11'd1;
                        n_a1 = crmc_pkg::set_mid(r_a1, crmc_pkg::mid(r_a1) & ram_q);
                    end
                    7'd46: begin
                        n_h1 = r_a1[15:0];
                        n_a1 = crmc_pkg::set_mid(r_a1, crmc_pkg::mid(r_a1) | crmc_pkg::mid(r_a0));
                    end
                    7'd47: begin
                        ram_we = 1'b1; ram_addr = crmc_pkg::slot(r_p3);
                        ram_wdata = crmc_pkg::mid(r_a1);
                        n_p3 = r_p3 - 11'd1;
                    end
                    7'd48: ram_addr = crmc_pkg::slot(r_p1);
                    7'd49: begin
                        n_a0 = crmc_pkg::set_mid(r_a0, ram_q & r_h1);
                        ram_addr = crmc_pkg::slot(r_p1);
                    end
                    7'd50: begin n_a1 = crmc_pkg::set_mid(r_a1, ~ram_q); n_p1 = r_p1 + 11'd1; end
                    7'd51: begin
                        n_h1 = crmc_pkg::mid(r_a0);
                        n_a1 = crmc_pkg::set_mid(r_a1,
                            (crmc_pkg::mid(r_a1) & r_h0) | crmc_pkg::mid(r_a0));
                        n_p1 = r_p1 - 11'd1;
                        n_p2 = r_p2 + 11'd1;
                    end
                    7'd52: begin
                        ram_we = 1'b1; ram_addr = crmc_pkg::slot(r_p3);
                        ram_wdata = crmc_pkg::mid(r_a1);
                        n_p3 = r_p3 - 11'd2;
                    end
                    7'd53: ram_addr = crmc_pkg::slot(r_p3);
                    7'd54: begin
                        n_h1 = ram_q; n_p3 = r_p3 + 11'd1;
                        n_a1 = crmc_pkg::set_mid(r_a1, crmc_pkg::mid(r_a1) ^ ram_q);
                    end
                    7'd55: ram_addr = crmc_pkg::slot(r_p1);
                    7'd56: begin
                        n_h1 = ram_q; n_p1 = r_p1 + 11'd1;
                        n_a1 = crmc_pkg::set_mid(r_a1, crmc_pkg::mid(r_a1) ^ ram_q);
                    end
                    7'd57: ram_addr = crmc_pkg::slot(r_p2);
                    7'd58: begin
                        n_h1 = ram_q; n_p2 = r_p2 + 11'd1; n_a1 = {16'b0, r_a1[39:16]};
                    end
                    7'd59: ram_addr = crmc_pkg::slot(r_p3);
                    7'd60: begin n_h0 = ram_q; n_p3 = r_p3 - 11'd2; end
                    7'd61: ram_addr = crmc_pkg::slot(r_p3);
                    7'd62: n_a1 = crmc_pkg::set_mid(r_a1, ram_q);
                    7'd63: begin
                        ram_we = 1'b1; ram_addr = crmc_pkg::slot(r_p2); ram_wdata = r_a1[15:0];
                        n_a1 = crmc_pkg::set_mid(r_a1, crmc_pkg::mid(r_a1) ^ r_h0);
                        n_p2 = r_p2 + 11'd1;
                    end
                    7'd64: n_a1 = crmc_pkg::set_mid(r_a1, crmc_pkg::mid(r_a1) ^ r_h1);
                    default: begin
                        ram_we = 1'b1; ram_addr = crmc_pkg::slot(r_p2);
                        ram_wdata = crmc_pkg::mid(r_a1);
                        n_p2 = r_p2 - 11'd1;
                        n_step = '0;
                        if (r_round != crmc_pkg::RoundLast) begin
                            n_a1    = crmc_pkg::set_low(r_a1, {12'b0, r_l1});
                            n_carry = r_nlo;
                            n_round = r_round + 3'd1;
                            n_bytes = {r_bytes[55:0], 8'b0};
                        end
                    end
                endcase
            end
            crmc_pkg::ST_KEY_A: ram_addr = crmc_pkg::slot(crmc_pkg::KeyHiAddr);
            crmc_pkg::ST_KEY_B: begin
                n_key_hi = ram_q;
                ram_addr = crmc_pkg::slot(crmc_pkg::KeyLoAddr);
            end
            crmc_pkg::ST_KEY_C: begin
                ram_addr = crmc_pkg::slot(crmc_pkg::KeyLoAddr);
                if (key_leave) begin
                    n_ovalid = 1'b1;
                    n_key    = {r_key_hi, ram_q};
                end
            end
            default: n_step = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= crmc_pkg::ST_IDLE;
            r_step   <= '0;
            r_round  <= 3'd1;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_step   <= n_step;
            r_round  <= n_round;
            r_ovalid <= n_ovalid;
        end
        r_bytes  <= n_bytes;
        r_sum    <= n_sum;
        r_a0     <= n_a0;
        r_a1     <= n_a1;
        r_p1     <= n_p1;
        r_p2     <= n_p2;
        r_p3     <= n_p3;
        r_h0     <= n_h0;
        r_h1     <= n_h1;
        r_l0     <= n_l0;
        r_l1     <= n_l1;
        r_nlo    <= n_nlo;
        r_carry  <= n_carry;
        r_key_hi <= n_key_hi;
        r_key    <= n_key;
    end

    assign o_stall = (r_state != crmc_pkg::ST_IDLE);
    assign o_valid = r_ovalid;
    assign o_key   = r_key;

`ifndef NO_ASSERTIONS
    a_key_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == crmc_pkg::ST_KEY_C))
        else $error("key valid raised outside key readout");
    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == crmc_pkg::ST_IDLE) |-> !ram_we)
        else $error("scratch write while idle");
    a_accept_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state == crmc_pkg::ST_CLEAR))
        else $error("request accepted without clearing scratch");
    a_round_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == crmc_pkg::ST_ROUND) |-> (r_round != 3'd0 && r_step <= crmc_pkg::StepRoundLast))
        else $error("round sequencer out of range");
`endif
endmodule

// ----- tb/tb_challenge_response_mix_cipher.sv -----
// Self-checking testbench for challenge_response_mix_cipher: a directed table of
// challenges, then random ones, with every key checked against an in-bench predictor.
// Depends on rtl/crmc_pkg.sv, rtl/crmc_ram.sv and rtl/challenge_response_mix_cipher.sv.
module tb_challenge_response_mix_cipher;

    localparam int NumRandom  = 1000;
    localparam int HoldCycles = 3000;
    localparam int DrainWait  = 700;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [31:0] i_challenge_high = '0;
    logic [31:0] i_challenge_low = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [31:0] o_key;

    challenge_response_mix_cipher dut (.*);

    always #6 i_clk = ~i_clk;

    // predictor state
    logic [15:0] scr [crmc_pkg::ScrDepth];
    logic [39:0] acc_a, acc_b;
    logic [10:0] ptr_one, ptr_two;
    logic [15:0] carry_nib;

    logic [31:0] key_queue [$];
    int          n_errors = 0;
    int          n_keys = 0;
    bit          calm = 1'b0;

    function automatic logic [5:0] scr_idx(input logic [10:0] a);
        return {a[10], a[4:0]};
    endfunction

    function automatic logic [39:0] var_shift(input logic [39:0] v, input logic [15:0] h);
        logic [5:0] s;
        s = h[5:0];
        if (s == 6'd0) return v;
        if (h[6]) return v >> (7'd64 - {1'b0, s});
        return v << s;
    endfunction

    task automatic mix_byte(input logic [7:0] b, output logic [15:0] nib_hi,
                            output logic [15:0] nib_lo);
        logic [39:0] a0, a1, t;
        logic [10:0] p1, p2, p3;
        logic [15:0] h0, h1, l0, l1;
        a0 = acc_a; a1 = acc_b; p1 = ptr_one; p2 = ptr_two; p3 = crmc_pkg::PtrThreeInit;
        h0 = carry_nib;
        l1 = {12'd0, b[7:4]};
        a0[15:0] = {12'd0, b[3:0]};
        nib_lo = {12'd0, b[3:0]};
        nib_hi = l1;
        a0 = a0 << 20;
        a0[31:16] |= h0;
        h1 = scr[scr_idx(p2)]; p2 += 11'd1;
        a0 = a0 << 16;
        h0 = scr[scr_idx(p2)]; p2 += 11'd1;
        a0 = {{16{a0[39]}}, a0[39:16]};
        p2 -= 11'd1;
        a1 = a1 << 24;
        a0[31:16] ^= a1[31:16];
        p2 -= 11'd1;
        a1[31:16] = l1;
        a1 = a1 << 12;
        a0[31:16] ^= a1[31:16];
        p2 -= 11'd1;
        l0 = a0[31:16];
        a0[15:0] = scr[scr_idx(p1)]; p1 -= 11'd1;
        a0[31:16] = scr[scr_idx(p1)]; p1 += 11'd1;
        a0 += {24'd0, l0};
        scr[scr_idx(p1)] = a0[15:0]; p1 -= 11'd1;
        a1[31:16] = scr[scr_idx(p2)]; p2 -= 11'd1;
        scr[scr_idx(p1)] = a0[31:16];
        a1[31:16] ^= h0;
        p1 += 11'd1;
        l0 = scr[scr_idx(p3)];
        a1 = a1 >> 16;
        p3 += 11'd1;
        a1[31:16] = scr[scr_idx(p2)]; p2 -= 11'd1;
        a1[31:16] ^= h1;
        a1 += a0;
        a0[15:0] = scr[scr_idx(p3)]; p3 += 11'd1;
        a0 += 40'd1;
        p3 -= 11'd1;
        scr[scr_idx(p3)] = a0[15:0]; p3 += 11'd1;
        a0 += {24'd0, l0};
        l0 = scr[scr_idx(p2)]; p2 += 11'd1;
        a0 = {35'd0, a0[4:0]};
        a0 = -a0;
        a0 = a0 << 16;
        a0 -= crmc_pkg::ShiftBias;
        h0 = a0[31:16];
        a0 += crmc_pkg::ShiftSpan;
        h1 = a0[31:16];
        a0 = a1 << 8;
        p3 = crmc_pkg::PtrTwoInit;
        a0 = var_shift(a0, h0);
        p2 -= 11'd1;
        a1 = var_shift(a1, h1);
        p2 -= 11'd1;
        a0 += a1;
        h0 = scr[scr_idx(p2)]; p2 += 11'd1;
        t = {{8{h0[15]}}, h0, l0};
        a0 += t;
        a1[15:0] = scr[scr_idx(p3)]; p3 += 11'd1;
        scr[scr_idx(p2)] = a0[15:0]; p2 -= 11'd1;
        scr[scr_idx(p2)] = a0[31:16];
        a0[31:16] = scr[scr_idx(p1)];
        a1[31:16] = scr[scr_idx(p1)]; p1 -= 11'd1;
        a1[31:16] ^= 16'hffff;
        h0 = scr[scr_idx(p2)]; p2 += 11'd1;
        h1 = scr[scr_idx(p3)]; p3 -= 11'd2;
        a0[31:16] &= h1;
        h1 = scr[scr_idx(p2)]; p2 += 11'd1;
        a1[31:16] &= h1;
        h1 = a0[31:16];
        a1[31:16] |= h1;
        h1 = a1[15:0];
        scr[scr_idx(p3)] = a1[31:16]; p3 -= 11'd1;
        a0[31:16] = scr[scr_idx(p1)];
        a0[31:16] &= h1;
        a1[31:16] = scr[scr_idx(p1)]; p1 += 11'd1;
        a1[31:16] ^= 16'hffff;
        h1 = a0[31:16];
        a1[31:16] &= h0;
        p1 -= 11'd1;
        a1[31:16] |= h1;
        p2 += 11'd1;
        scr[scr_idx(p3)] = a1[31:16]; p3 -= 11'd2;
        h1 = scr[scr_idx(p3)]; p3 += 11'd1;
        a1[31:16] ^= h1;
        h1 = scr[scr_idx(p1)]; p1 += 11'd1;
        a1[31:16] ^= h1;
        h1 = scr[scr_idx(p2)]; p2 += 11'd1;
        a1 = a1 >> 16;
        h0 = scr[scr_idx(p3)]; p3 -= 11'd2;
        a1[31:16] = scr[scr_idx(p3)];
        scr[scr_idx(p2)] = a1[15:0];
        a1[31:16] ^= h0;
        p2 += 11'd1;
        a1[31:16] ^= h1;
        scr[scr_idx(p2)] = a1[31:16];
        p2 -= 11'd1;
        acc_a = a0; acc_b = a1; ptr_one = p1; ptr_two = p2;
    endtask

    task automatic predict_key(input logic [31:0] hi, input logic [31:0] lo,
                               output logic [31:0] key);
        logic [63:0] bytes;
        logic [7:0]  b [8];
        logic [15:0] sum, nh, nl;
        bytes = {hi, lo};
        sum = '0;
        for (int i = 0; i < 8; i++) begin
            b[i] = bytes[63 - 8 * i -: 8];
            sum += {8'd0, b[i]};
        end
        foreach (scr[i]) scr[i] = '0;
        scr[scr_idx(11'h403)] = 16'h0008;
        scr[scr_idx(11'h408)] = 16'h170a;
        scr[scr_idx(11'h409)] = 16'h7489 + sum;
        scr[scr_idx(11'h40a)] = 16'h05ef;
        scr[scr_idx(11'h40b)] = 16'he0aa;
        scr[scr_idx(11'h40c)] = 16'hdaf4;
        scr[scr_idx(11'h40d)] = 16'hb157;
        scr[scr_idx(11'h40e)] = 16'h6bbe;
        scr[scr_idx(11'h40f)] = 16'hc3b6;
        scr[scr_idx(11'h410)] = sum + 16'd8;
        ptr_one = crmc_pkg::PtrOneInit;
        ptr_two = crmc_pkg::PtrTwoInit;
        acc_a = '0;
        acc_b = crmc_pkg::AccBInit | {36'd0, b[0][7:4]};
        carry_nib = {12'd0, b[0][3:0]};
        for (int r = 1; r < 8; r++) begin
            mix_byte(b[r], nh, nl);
            if (r < 7) begin
                acc_b[15:0] = nh;
                carry_nib = nl;
            end
        end
        key = {scr[scr_idx(crmc_pkg::KeyHiAddr)], scr[scr_idx(crmc_pkg::KeyLoAddr)]};
    endtask

    task automatic send_request(input logic [31:0] hi, input logic [31:0] lo);
        logic [31:0] k;
        while (!calm && $urandom_range(99) < 15) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_challenge_high <= hi;
        i_challenge_low <= lo;
        do @(posedge i_clk); while (o_stall);
        predict_key(hi, lo, k);
        key_queue.push_back(k);
    endtask

    // receiver: check, then pick the next stall
    int hold_left = 0;
    bit held = 1'b0;
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            n_keys++;
            if (key_queue.size() == 0) begin
                $error("key %08h with no request pending", o_key);
                n_errors++;
            end else begin
                logic [31:0] want;
                want = key_queue.pop_front();
                if (o_key !== want) begin
                    $error("key: expected %08h, actual %08h", want, o_key);
                    n_errors++;
                end
            end
        end
        if (!held && n_keys == 100) begin
            held = 1'b1;
            hold_left = HoldCycles;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= !calm && ($urandom_range(99) < 15);
        end
    end

    logic [63:0] directed [16] = '{
        64'h0000000000000000, 64'hffffffffffffffff, 64'h8000000000000001,
        64'h0000000100000000, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa,
        64'h0123456789abcdef, 64'hfedcba9876543210, 64'hff00ff00ff00ff00,
        64'h00ff00ff00ff00ff, 64'h0f0f0f0f0f0f0f0f, 64'hf0f0f0f0f0f0f0f0,
        64'h7fffffffffffffff, 64'hffffffff00000000, 64'h00000000ffffffff,
        64'h1f1f1f1f1f1f1f1f
    };

    initial begin
        logic [31:0] hi, lo;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (directed[i]) send_request(directed[i][63:32], directed[i][31:0]);
        for (int n = 0; n < NumRandom; n++) begin
            if (n == 400) calm = 1'b1;
            if (n == 600) calm = 1'b0;
            if (n == 700) begin
                i_valid <= 1'b0;
                while (key_queue.size() != 0) @(posedge i_clk);
            end
            hi = $urandom;
            lo = $urandom;
            if ($urandom_range(9) == 0) hi = $urandom_range(1) ? '1 : '0;
            if ($urandom_range(9) == 0) lo = $urandom_range(1) ? '1 : '0;
            send_request(hi, lo);
        end
        i_valid <= 1'b0;
        while (key_queue.size() != 0) @(posedge i_clk);
        repeat (DrainWait) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #(12 * 4000000);
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- challenge_response_mix_cipher.f -----
rtl/crmc_pkg.sv
rtl/crmc_ram.sv
rtl/challenge_response_mix_cipher.sv
tb/tb_challenge_response_mix_cipher.sv
